FILE: hdl/nrmp_pkg.sv
// Shared types, constants and the control program of the nested recurrence block.
// Used by nrmp_seq, nrmp_dp and nested_recurrence_matrix_power_top; no dependencies.
package nrmp_pkg;

    localparam int unsigned COEF_WIDTH  = 20;
    localparam int unsigned INDEX_WIDTH = 64;
    localparam int unsigned PC_WIDTH    = 5;

    localparam logic [COEF_WIDTH-1:0] RESIDUE_MOD = 20'd1000007;

    // Barrett reduction: quotient ~ ((s >> BARRETT_PRE) * BARRETT_RECIP) >> (SHIFT - PRE)
    localparam int unsigned BARRETT_PRE   = 9;
    localparam int unsigned BARRETT_SHIFT = 51;
    localparam logic [63:0] BARRETT_WIDE  = (64'd1 << BARRETT_SHIFT) / 64'd1000007;
    localparam logic [31:0] BARRETT_RECIP = BARRETT_WIDE[31:0];

    // configuration register indexes
    localparam logic CFG_COEF_PREV  = 1'b0;
    localparam logic CFG_COEF_PREV2 = 1'b1;

    // program labels
    localparam logic [PC_WIDTH-1:0] PC_IDLE     = 5'd0;
    localparam logic [PC_WIDTH-1:0] PC_TOP      = 5'd1;
    localparam logic [PC_WIDTH-1:0] PC_MUL      = 5'd3;
    localparam logic [PC_WIDTH-1:0] PC_SQ       = 5'd4;
    localparam logic [PC_WIDTH-1:0] PC_DISPATCH = 5'd5;
    localparam logic [PC_WIDTH-1:0] PC_W0       = 5'd6;
    localparam logic [PC_WIDTH-1:0] PC_M0       = 5'd14;
    localparam logic [PC_WIDTH-1:0] PC_COMMIT   = 5'd21;
    localparam logic [PC_WIDTH-1:0] PC_PASS_END = 5'd23;
    localparam logic [PC_WIDTH-1:0] PC_FIN      = 5'd25;

    typedef struct packed {
        logic [63:0] e00;
        logic [63:0] e01;
        logic [63:0] e10;
        logic [63:0] e11;
    } mat_t;

    localparam mat_t MAT_IDENT = '{e00: 64'd1, e01: 64'd0, e10: 64'd0, e11: 64'd1};

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_INIT,
        ACT_SET_MUL,
        ACT_SET_SQ,
        ACT_COMMIT,
        ACT_SHIFT,
        ACT_SECOND,
        ACT_OUT_LOAD
    } action_t;

    typedef enum logic [1:0] {
        OPA_P_LO,
        OPA_P_HI,
        OPA_SUM,
        OPA_QUOT
    } opa_t;

    typedef enum logic [1:0] {
        OPB_Q_LO,
        OPB_Q_HI,
        OPB_RECIP,
        OPB_MOD
    } opb_t;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_SH,
        ACC_SUB
    } accop_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_WRAP,
        WR_MOD
    } wr_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_START,
        C_EXP_ZERO,
        C_EXP_EVEN,
        C_MOD,
        C_NOT_LAST,
        C_USE_ACC,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        action_t action;
        opa_t    opa;
        opb_t    opb;
        logic    k;
        accop_t  acc_op;
        wr_t     wr;
        logic    el_inc;
    } ctrl_t;

    typedef struct packed {
        logic exp_zero;
        logic exp_even;
        logic mod;
        logic last_el;
        logic use_acc;
        logic out_busy;
    } stat_t;

    typedef struct packed {
        ctrl_t                ctrl;
        cond_t                cond;
        logic [PC_WIDTH-1:0]  target;
    } uword_t;

    function automatic logic [63:0] mat_pick(input mat_t m, input logic [1:0] idx);
        logic [63:0] v;
        case (idx)
            2'd0:    v = m.e00;
            2'd1:    v = m.e01;
            2'd2:    v = m.e10;
            default: v = m.e11;
        endcase
        return v;
    endfunction

    function automatic mat_t mat_set(input mat_t m, input logic [1:0] idx,
                                     input logic [63:0] v);
        mat_t r;
        r = m;
        case (idx)
            2'd0:    r.e00 = v;
            2'd1:    r.e01 = v;
            2'd2:    r.e10 = v;
            default: r.e11 = v;
        endcase
        return r;
    endfunction

    function automatic uword_t uw(input action_t a, input opa_t pa, input opb_t pb,
                                  input logic k, input accop_t op, input wr_t wr,
                                  input logic inc, input cond_t c,
                                  input logic [PC_WIDTH-1:0] t);
        uword_t w;
        w.ctrl.action = a;
        w.ctrl.opa    = pa;
        w.ctrl.opb    = pb;
        w.ctrl.k      = k;
        w.ctrl.acc_op = op;
        w.ctrl.wr     = wr;
        w.ctrl.el_inc = inc;
        w.cond        = c;
        w.target      = t;
        return w;
    endfunction

    // Control program. Wrap element: six partial products of a 64-bit wrapping
    // dot product; modular element: two products, Barrett quotient, q*M, subtract.
    // Products are registered, so accumulate ops run in the step after their products.
    function automatic uword_t rom_word(input logic [PC_WIDTH-1:0] pc);
        uword_t w;
        w = uw(ACT_NONE, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_NONE, WR_NONE, 1'b0, C_NEVER, PC_IDLE);
        case (pc)
            PC_IDLE:
                w = uw(ACT_INIT, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_NONE, WR_NONE, 1'b0,
                       C_NOT_START, PC_IDLE);
            PC_TOP:
                w = uw(ACT_NONE, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_NONE, WR_NONE, 1'b0,
                       C_EXP_ZERO, PC_PASS_END);
            PC_TOP + 5'd1:
                w = uw(ACT_NONE, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_NONE, WR_NONE, 1'b0,
                       C_EXP_EVEN, PC_SQ);
            PC_MUL:
                w = uw(ACT_SET_MUL, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_NONE, WR_NONE, 1'b0,
                       C_ALWAYS, PC_DISPATCH);
            PC_SQ:
                w = uw(ACT_SET_SQ, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_NONE, WR_NONE, 1'b0,
                       C_NEVER, PC_IDLE);
            PC_DISPATCH:
                w = uw(ACT_NONE, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_NONE, WR_NONE, 1'b0,
                       C_MOD, PC_M0);
            // wrapping element
            PC_W0:
                w = uw(ACT_NONE, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_NONE, WR_NONE, 1'b0,
                       C_NEVER, PC_IDLE);
            PC_W0 + 5'd1:
                w = uw(ACT_NONE, OPA_P_LO, OPB_Q_HI, 1'b0, ACC_LOAD, WR_NONE, 1'b0,
                       C_NEVER, PC_IDLE);
            PC_W0 + 5'd2:
                w = uw(ACT_NONE, OPA_P_HI, OPB_Q_LO, 1'b0, ACC_ADD_SH, WR_NONE, 1'b0,
                       C_NEVER, PC_IDLE);
            PC_W0 + 5'd3:
                w = uw(ACT_NONE, OPA_P_LO, OPB_Q_LO, 1'b1, ACC_ADD_SH, WR_NONE, 1'b0,
                       C_NEVER, PC_IDLE);
            PC_W0 + 5'd4:
                w = uw(ACT_NONE, OPA_P_LO, OPB_Q_HI, 1'b1, ACC_ADD, WR_NONE, 1'b0,
                       C_NEVER, PC_IDLE);
            PC_W0 + 5'd5:
                w = uw(ACT_NONE, OPA_P_HI, OPB_Q_LO, 1'b1, ACC_ADD_SH, WR_NONE, 1'b0,
                       C_NEVER, PC_IDLE);
            PC_W0 + 5'd6:
                w = uw(ACT_NONE, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_ADD_SH, WR_WRAP, 1'b1,
                       C_NOT_LAST, PC_W0);
            PC_W0 + 5'd7:
                w = uw(ACT_NONE, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_NONE, WR_NONE, 1'b0,
                       C_ALWAYS, PC_COMMIT);
            // modular element
            PC_M0:
                w = uw(ACT_NONE, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_NONE, WR_NONE, 1'b0,
                       C_NEVER, PC_IDLE);
            PC_M0 + 5'd1:
                w = uw(ACT_NONE, OPA_P_LO, OPB_Q_LO, 1'b1, ACC_LOAD, WR_NONE, 1'b0,
                       C_NEVER, PC_IDLE);
            PC_M0 + 5'd2:
                w = uw(ACT_NONE, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_ADD, WR_NONE, 1'b0,
                       C_NEVER, PC_IDLE);
            PC_M0 + 5'd3:
                w = uw(ACT_NONE, OPA_SUM, OPB_RECIP, 1'b0, ACC_NONE, WR_NONE, 1'b0,
                       C_NEVER, PC_IDLE);
            PC_M0 + 5'd4:
                w = uw(ACT_NONE, OPA_QUOT, OPB_MOD, 1'b0, ACC_NONE, WR_NONE, 1'b0,
                       C_NEVER, PC_IDLE);
            PC_M0 + 5'd5:
                w = uw(ACT_NONE, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_SUB, WR_NONE, 1'b0,
                       C_NEVER, PC_IDLE);
            PC_M0 + 5'd6:
                w = uw(ACT_NONE, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_NONE, WR_MOD, 1'b1,
                       C_NOT_LAST, PC_M0);
            PC_COMMIT:
                w = uw(ACT_COMMIT, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_NONE, WR_NONE, 1'b0,
                       C_USE_ACC, PC_SQ);
            PC_COMMIT + 5'd1:
                w = uw(ACT_SHIFT, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_NONE, WR_NONE, 1'b0,
                       C_ALWAYS, PC_TOP);
            PC_PASS_END:
                w = uw(ACT_NONE, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_NONE, WR_NONE, 1'b0,
                       C_MOD, PC_FIN);
            PC_PASS_END + 5'd1:
                w = uw(ACT_SECOND, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_NONE, WR_NONE, 1'b0,
                       C_ALWAYS, PC_TOP);
            PC_FIN:
                w = uw(ACT_NONE, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_NONE, WR_NONE, 1'b0,
                       C_OUT_BUSY, PC_FIN);
            PC_FIN + 5'd1:
                w = uw(ACT_OUT_LOAD, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_NONE, WR_NONE, 1'b0,
                       C_ALWAYS, PC_IDLE);
            default:
                w = uw(ACT_NONE, OPA_P_LO, OPB_Q_LO, 1'b0, ACC_NONE, WR_NONE, 1'b0,
                       C_ALWAYS, PC_IDLE);
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/nested_recurrence_matrix_power_top.sv
// Top level of the nested recurrence block: configuration registers, sequencer, datapath.
// Depends on nrmp_pkg, nrmp_seq and nrmp_dp.
//
// Each request index_n yields result_value = f(f(n) mod 2^64) mod 1000007, where
// f(k) = x*f(k-1) + y*f(k-2), f(0) = 0, f(1) = 1, with x and y taken from coef_prev and
// coef_prev2 (both reset to 1, written by the user through cfg_wr_en/cfg_index/cfg_data
// only while idle; the block does not enforce this). One request is in work at a time;
// the result sits in an output register, so the next request is taken while it waits.
// Both passes run square-and-multiply on 2x2 matrices through one shared 32x32
// multiplier stepped by the microcode program. The first pass wraps at 64 bits and
// takes six partial products per element; the second pass runs on exponent f(n) and
// takes four products per element: two partial products, the Barrett quotient and q*M.
module nested_recurrence_matrix_power_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [nrmp_pkg::COEF_WIDTH-1:0]     cfg_data,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [nrmp_pkg::INDEX_WIDTH-1:0]    index_n,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [nrmp_pkg::COEF_WIDTH-1:0]     result_value
);

    logic [nrmp_pkg::COEF_WIDTH-1:0] coef_prev_reg;
    logic [nrmp_pkg::COEF_WIDTH-1:0] coef_prev2_reg;
    nrmp_pkg::ctrl_t                 ctrl;
    nrmp_pkg::stat_t                 stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_prev_reg  <= 20'd1;
            coef_prev2_reg <= 20'd1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                nrmp_pkg::CFG_COEF_PREV:  coef_prev_reg  <= cfg_data;
                nrmp_pkg::CFG_COEF_PREV2: coef_prev2_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    nrmp_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    nrmp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .index_n      (index_n),
        .coef_prev    (coef_prev_reg),
        .coef_prev2   (coef_prev2_reg),
        .rsp_stall    (rsp_stall),
        .stat         (stat),
        .rsp_valid    (rsp_valid),
        .result_value (result_value)
    );

endmodule

FILE: hdl/nrmp_seq.sv
// Microcode sequencer: step counter, program lookup and conditional jumps.
// Depends on nrmp_pkg for the program table, control word and status types.
module nrmp_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  nrmp_pkg::stat_t stat,
    output nrmp_pkg::ctrl_t ctrl
);

    logic [nrmp_pkg::PC_WIDTH-1:0] pc_reg;
    logic [nrmp_pkg::PC_WIDTH-1:0] pc_next;
    nrmp_pkg::uword_t              word;
    logic                          start;
    logic                          take;

    assign word      = nrmp_pkg::rom_word(pc_reg);
    assign req_stall = (pc_reg != nrmp_pkg::PC_IDLE);
    assign start     = req_valid && (pc_reg == nrmp_pkg::PC_IDLE);

    always_comb
    begin
        case (word.cond)
            nrmp_pkg::C_NEVER:     take = 1'b0;
            nrmp_pkg::C_ALWAYS:    take = 1'b1;
            nrmp_pkg::C_NOT_START: take = !start;
            nrmp_pkg::C_EXP_ZERO:  take = stat.exp_zero;
            nrmp_pkg::C_EXP_EVEN:  take = stat.exp_even;
            nrmp_pkg::C_MOD:       take = stat.mod;
            nrmp_pkg::C_NOT_LAST:  take = !stat.last_el;
            nrmp_pkg::C_USE_ACC:   take = stat.use_acc;
            nrmp_pkg::C_OUT_BUSY:  take = stat.out_busy;
            default:               take = 1'b0;
        endcase
        pc_next = take ? word.target : pc_reg + 5'd1;
    end

    // the load of a new request only fires on the accepting edge
    always_comb
    begin
        ctrl = word.ctrl;
        if ((word.ctrl.action == nrmp_pkg::ACT_INIT) && !start)
        begin
            ctrl.action = nrmp_pkg::ACT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= nrmp_pkg::PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: hdl/nrmp_dp.sv
// Datapath: matrix registers, shared 32x32 multiplier, accumulator, Barrett fix-up
// and the result register. Driven by nrmp_seq control words; depends on nrmp_pkg.
module nrmp_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nrmp_pkg::ctrl_t                     ctrl,
    input  logic [nrmp_pkg::INDEX_WIDTH-1:0]    index_n,
    input  logic [nrmp_pkg::COEF_WIDTH-1:0]     coef_prev,
    input  logic [nrmp_pkg::COEF_WIDTH-1:0]     coef_prev2,
    input  logic                                rsp_stall,
    output nrmp_pkg::stat_t                     stat,
    output logic                                rsp_valid,
    output logic [nrmp_pkg::COEF_WIDTH-1:0]     result_value
);

    nrmp_pkg::mat_t acc_reg, acc_next;
    nrmp_pkg::mat_t base_reg, base_next;
    nrmp_pkg::mat_t tmp_reg, tmp_next;

    logic [63:0] exp_reg, exp_next;
    logic [63:0] sum_reg, sum_next;
    logic [63:0] prod_reg, prod_next;
    logic [1:0]  el_reg, el_next;
    logic        use_acc_reg, use_acc_next;
    logic        mod_reg, mod_next;
    logic        out_valid_reg, out_valid_next;
    logic [nrmp_pkg::COEF_WIDTH-1:0] result_reg, result_next;

    logic [63:0] p_elem;
    logic [63:0] q_elem;
    logic [31:0] opa;
    logic [31:0] opb;
    logic [20:0] resid;
    logic [20:0] resid_fix;
    logic [63:0] wr_val;
    logic [nrmp_pkg::COEF_WIDTH-1:0] x_red;
    logic [nrmp_pkg::COEF_WIDTH-1:0] y_red;

    function automatic logic [nrmp_pkg::COEF_WIDTH-1:0] reduce_once(
        input logic [nrmp_pkg::COEF_WIDTH-1:0] c);
        return (c >= nrmp_pkg::RESIDUE_MOD) ? c - nrmp_pkg::RESIDUE_MOD : c;
    endfunction

    assign x_red = reduce_once(coef_prev);
    assign y_red = reduce_once(coef_prev2);

    // element (i,j) = sum over k of p(i,k) * q(k,j); i, j from the element counter
    assign p_elem = use_acc_reg ? nrmp_pkg::mat_pick(acc_reg, {el_reg[1], ctrl.k})
                                : nrmp_pkg::mat_pick(base_reg, {el_reg[1], ctrl.k});
    assign q_elem = nrmp_pkg::mat_pick(base_reg, {ctrl.k, el_reg[0]});

    always_comb
    begin
        case (ctrl.opa)
            nrmp_pkg::OPA_P_LO: opa = p_elem[31:0];
            nrmp_pkg::OPA_P_HI: opa = p_elem[63:32];
            nrmp_pkg::OPA_SUM:  opa = sum_reg[nrmp_pkg::BARRETT_PRE+31:nrmp_pkg::BARRETT_PRE];
            nrmp_pkg::OPA_QUOT:
                opa = 32'(prod_reg[63:nrmp_pkg::BARRETT_SHIFT-nrmp_pkg::BARRETT_PRE]);
            default:            opa = p_elem[31:0];
        endcase
        case (ctrl.opb)
            nrmp_pkg::OPB_Q_LO:  opb = q_elem[31:0];
            nrmp_pkg::OPB_Q_HI:  opb = q_elem[63:32];
            nrmp_pkg::OPB_RECIP: opb = nrmp_pkg::BARRETT_RECIP;
            nrmp_pkg::OPB_MOD:   opb = 32'(nrmp_pkg::RESIDUE_MOD);
            default:             opb = q_elem[31:0];
        endcase
    end

    assign prod_next = 64'(opa) * 64'(opb);

    always_comb
    begin
        case (ctrl.acc_op)
            nrmp_pkg::ACC_NONE:   sum_next = sum_reg;
            nrmp_pkg::ACC_LOAD:   sum_next = prod_reg;
            nrmp_pkg::ACC_ADD:    sum_next = sum_reg + prod_reg;
            nrmp_pkg::ACC_ADD_SH: sum_next = sum_reg + {prod_reg[31:0], 32'd0};
            nrmp_pkg::ACC_SUB:    sum_next = sum_reg - prod_reg;
            default:              sum_next = sum_reg;
        endcase
    end

    // Barrett quotient is low by at most one, so the residue is below twice M
    assign resid     = sum_reg[20:0];
    assign resid_fix = (resid >= 21'(nrmp_pkg::RESIDUE_MOD))
                       ? resid - 21'(nrmp_pkg::RESIDUE_MOD) : resid;
    assign wr_val    = (ctrl.wr == nrmp_pkg::WR_MOD) ? 64'(resid_fix) : sum_next;

    always_comb
    begin
        acc_next       = acc_reg;
        base_next      = base_reg;
        tmp_next       = tmp_reg;
        exp_next       = exp_reg;
        el_next        = el_reg;
        use_acc_next   = use_acc_reg;
        mod_next       = mod_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        result_next    = result_reg;

        if (ctrl.wr != nrmp_pkg::WR_NONE)
        begin
            tmp_next = nrmp_pkg::mat_set(tmp_reg, el_reg, wr_val);
        end
        if (ctrl.el_inc)
        begin
            el_next = el_reg + 2'd1;
        end

        case (ctrl.action)
            nrmp_pkg::ACT_NONE:
            begin
            end
            nrmp_pkg::ACT_INIT:
            begin
                exp_next  = index_n;
                mod_next  = 1'b0;
                acc_next  = nrmp_pkg::MAT_IDENT;
                base_next = '{e00: 64'(coef_prev), e01: 64'(coef_prev2),
                              e10: 64'd1, e11: 64'd0};
            end
            nrmp_pkg::ACT_SET_MUL:
            begin
                use_acc_next = 1'b1;
                el_next      = 2'd0;
            end
            nrmp_pkg::ACT_SET_SQ:
            begin
                use_acc_next = 1'b0;
                el_next      = 2'd0;
            end
            nrmp_pkg::ACT_COMMIT:
            begin
                if (use_acc_reg)
                begin
                    acc_next = tmp_reg;
                end
                else
                begin
                    base_next = tmp_reg;
                end
            end
            nrmp_pkg::ACT_SHIFT:
            begin
                exp_next = {1'b0, exp_reg[63:1]};
            end
            nrmp_pkg::ACT_SECOND:
            begin
                exp_next  = acc_reg.e10;
                mod_next  = 1'b1;
                acc_next  = nrmp_pkg::MAT_IDENT;
                base_next = '{e00: 64'(x_red), e01: 64'(y_red), e10: 64'd1, e11: 64'd0};
            end
            nrmp_pkg::ACT_OUT_LOAD:
            begin
                out_valid_next = 1'b1;
                result_next    = acc_reg.e10[nrmp_pkg::COEF_WIDTH-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            el_reg        <= 2'd0;
            use_acc_reg   <= 1'b0;
            mod_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            el_reg        <= el_next;
            use_acc_reg   <= use_acc_next;
            mod_reg       <= mod_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        base_reg   <= base_next;
        tmp_reg    <= tmp_next;
        exp_reg    <= exp_next;
        sum_reg    <= sum_next;
        prod_reg   <= prod_next;
        result_reg <= result_next;
    end

    assign stat.exp_zero = (exp_reg == 64'd0);
    assign stat.exp_even = !exp_reg[0];
    assign stat.mod      = mod_reg;
    assign stat.last_el  = (el_reg == 2'd3);
    assign stat.use_acc  = use_acc_reg;
    assign stat.out_busy = out_valid_reg && rsp_stall;

    assign rsp_valid    = out_valid_reg;
    assign result_value = result_reg;

`ifndef SYNTHESIS
    a_resid_below_twice: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.wr == nrmp_pkg::WR_MOD) |-> (sum_reg < (64'(nrmp_pkg::RESIDUE_MOD) << 1)))
        else $error("residue before fix-up not below twice the modulus");
    a_mod_pass_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        mod_reg |-> ((acc_reg.e10 < 64'(nrmp_pkg::RESIDUE_MOD))
                     && (base_reg.e00 < 64'(nrmp_pkg::RESIDUE_MOD))))
        else $error("matrix element not reduced in modular pass");
    a_commit_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.action == nrmp_pkg::ACT_COMMIT) |-> (el_reg == 2'd0))
        else $error("commit with element counter not wrapped");
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.action == nrmp_pkg::ACT_OUT_LOAD) |-> !out_valid_reg)
        else $error("result register overwritten while still pending");
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg < nrmp_pkg::RESIDUE_MOD))
        else $error("result out of range");
`endif

endmodule

FILE: sim/nrmp_checker.sv
// Result checker for the nested recurrence block: mirrors the coefficient registers,
// predicts result_value for each request and compares it with the returned results.
// Depends on nrmp_pkg; instantiated by tb beside the block.
`timescale 1ns / 1ps

module nrmp_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [nrmp_pkg::COEF_WIDTH-1:0]  cfg_data,
    input  logic                             req_valid,
    input  logic                             req_stall,
    input  logic [nrmp_pkg::INDEX_WIDTH-1:0] index_n,
    input  logic                             rsp_valid,
    input  logic                             rsp_stall,
    input  logic [nrmp_pkg::COEF_WIDTH-1:0]  result_value,
    output int                               errors,
    output int                               pending_results,
    output int                               results_checked
);

    // [[a, b], [c, d]]
    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } mat2_t;

    localparam logic [63:0] MODULUS = {44'd0, nrmp_pkg::RESIDUE_MOD};

    logic [nrmp_pkg::COEF_WIDTH-1:0] coef_x;
    logic [nrmp_pkg::COEF_WIDTH-1:0] coef_y;
    logic [nrmp_pkg::COEF_WIDTH-1:0] expected_values[$];
    logic [nrmp_pkg::COEF_WIDTH-1:0] want;

    // 64-bit products wrap; with reduce set every element is taken mod 1000007
    function automatic mat2_t mat_mul(input mat2_t p, input mat2_t q, input bit reduce);
        mat2_t r;
        r.a = p.a * q.a + p.b * q.c;
        r.b = p.a * q.b + p.b * q.d;
        r.c = p.c * q.a + p.d * q.c;
        r.d = p.c * q.b + p.d * q.d;
        if (reduce)
        begin
            r.a = r.a % MODULUS;
            r.b = r.b % MODULUS;
            r.c = r.c % MODULUS;
            r.d = r.d % MODULUS;
        end
        return r;
    endfunction

    // f(n) as the lower-left element of [[x, y], [1, 0]]^n
    function automatic logic [63:0] recurrence_term(input logic [63:0] n,
                                                    input logic [63:0] x,
                                                    input logic [63:0] y,
                                                    input bit reduce);
        mat2_t       acc;
        mat2_t       base;
        logic [63:0] e;
        acc  = '{64'd1, 64'd0, 64'd0, 64'd1};
        base = '{x, y, 64'd1, 64'd0};
        if (reduce)
        begin
            base.a = x % MODULUS;
            base.b = y % MODULUS;
        end
        e = n;
        while (e != 64'd0)
        begin
            if (e[0])
                acc = mat_mul(acc, base, reduce);
            base = mat_mul(base, base, reduce);
            e = e >> 1;
        end
        return acc.c;
    endfunction

    function automatic logic [nrmp_pkg::COEF_WIDTH-1:0] nested_term(input logic [63:0] n);
        logic [63:0] inner;
        logic [63:0] outer;
        inner = recurrence_term(n, {44'd0, coef_x}, {44'd0, coef_y}, 1'b0);
        outer = recurrence_term(inner, {44'd0, coef_x}, {44'd0, coef_y}, 1'b1);
        return outer[nrmp_pkg::COEF_WIDTH-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x <= 20'd1;
            coef_y <= 20'd1;
            expected_values.delete();
            errors          = 0;
            pending_results = 0;
            results_checked = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == nrmp_pkg::CFG_COEF_PREV)
                    coef_x <= cfg_data;
                else
                    coef_y <= cfg_data;
            end
            if (req_valid && !req_stall)
                expected_values.push_back(nested_term(index_n));
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_values.size() == 0)
                begin
                    $display("%0t: result_value %0d arrived with no request pending",
                             $time, result_value);
                    errors++;
                end
                else
                begin
                    want = expected_values.pop_front();
                    results_checked++;
                    if (result_value !== want)
                    begin
                        $display("%0t: result_value mismatch, expected %0d, got %0d",
                                 $time, want, result_value);
                        errors++;
                    end
                end
            end
            pending_results = expected_values.size();
        end
    end

endmodule

FILE: sim/tb.sv
// Top of the nested recurrence testbench: clock, reset, request and coefficient stimulus,
// result-side stalls, watchdog and verdict. Depends on nrmp_pkg, nrmp_checker and
// nested_recurrence_matrix_power_top.
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT  = 60000;
    localparam int END_WAIT    = 9000;
    localparam int BLOCKS      = 12;
    localparam int BLOCK_ITEMS = 47;

    logic                             clk;
    logic                             rst_n     = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic                             cfg_index = nrmp_pkg::CFG_COEF_PREV;
    logic [nrmp_pkg::COEF_WIDTH-1:0]  cfg_data  = '0;
    logic                             req_valid = 1'b0;
    logic                             req_stall;
    logic [nrmp_pkg::INDEX_WIDTH-1:0] index_n   = '0;
    logic                             rsp_valid;
    logic                             rsp_stall = 1'b0;
    logic [nrmp_pkg::COEF_WIDTH-1:0]  result_value;

    int sender_idle_pct   = 20;
    int receiver_idle_pct = 59;
    int idle_cycles       = 0;
    int requests_sent     = 0;
    int settings_used     = 1;
    int errors;
    int results_pending;
    int results_checked;

    nested_recurrence_matrix_power_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .index_n      (index_n),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .result_value (result_value)
    );

    nrmp_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .index_n         (index_n),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .result_value    (result_value),
        .errors          (errors),
        .pending_results (results_pending),
        .results_checked (results_checked)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(negedge clk)
        rsp_stall <= ($urandom_range(99) < receiver_idle_pct);

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout, nothing moved for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, results_pending);
            $display("tb NOT OK");
            $finish;
        end
    end

    // starts and ends at a falling edge; valid stays up between back-to-back requests
    task automatic send_index(input logic [nrmp_pkg::INDEX_WIDTH-1:0] n);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            index_n   <= {$urandom, $urandom};
            @(negedge clk);
        end
        req_valid <= 1'b1;
        index_n   <= n;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
        requests_sent++;
    endtask

    task automatic drain_results;
        req_valid <= 1'b0;
        @(negedge clk);
        while (results_pending != 0)
            @(negedge clk);
    endtask

    task automatic write_coefs(input logic [nrmp_pkg::COEF_WIDTH-1:0] x,
                               input logic [nrmp_pkg::COEF_WIDTH-1:0] y);
        drain_results();
        repeat (4) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= nrmp_pkg::CFG_COEF_PREV;
        cfg_data  <= x;
        @(negedge clk);
        cfg_index <= nrmp_pkg::CFG_COEF_PREV2;
        cfg_data  <= y;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    function automatic logic [nrmp_pkg::COEF_WIDTH-1:0] pick_coef();
        case ($urandom_range(5))
            0:       return '0;
            1:       return nrmp_pkg::RESIDUE_MOD - 20'd1;
            2:       return '1;
            3:       return 20'($urandom_range(1, 9));
            default: return 20'($urandom_range(20'hFFFFF));
        endcase
    endfunction

    // mostly short indexes to keep the first pass brief; a quarter use all 64 bits
    function automatic logic [nrmp_pkg::INDEX_WIDTH-1:0] random_index();
        logic [nrmp_pkg::INDEX_WIDTH-1:0] v;
        int unsigned                      w;
        v = {$urandom, $urandom};
        if ($urandom_range(3) != 0)
        begin
            w = $urandom_range(1, 20);
            v = v & ((64'd1 << w) - 64'd1);
        end
        return v;
    endfunction

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset coefficients: plain Fibonacci, zero index, wrap of the inner term
        send_index(64'd0);
        send_index(64'd1);
        send_index(64'd2);
        send_index(64'd3);
        send_index(64'd10);
        send_index(64'd93);
        send_index(64'hFFFF_FFFF_FFFF_FFFF);
        send_index(64'h8000_0000_0000_0000);
        send_index(64'h5555_5555_5555_5555);
        send_index(64'hAAAA_AAAA_AAAA_AAAA);

        // both coefficients zero: inner term goes to zero from n = 2
        write_coefs('0, '0);
        send_index(64'd0);
        send_index(64'd1);
        send_index(64'd2);
        send_index(64'd5);

        // coefficients above the modulus
        write_coefs('1, '1);
        send_index(64'd1);
        send_index(64'd2);
        send_index(64'd7);
        send_index(64'hFFFF_FFFF_FFFF_FFFF);

        write_coefs(nrmp_pkg::RESIDUE_MOD - 20'd1, '0);
        send_index(64'd3);
        send_index(64'hFFFF_FFFF_FFFF_FFFF);

        write_coefs('0, nrmp_pkg::RESIDUE_MOD - 20'd1);
        send_index(64'd4);
        send_index(64'd100);

        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            if (blk == BLOCKS / 3)
            begin
                sender_idle_pct   = 59;
                receiver_idle_pct = 20;
            end
            else if (blk == 2 * BLOCKS / 3)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            write_coefs(pick_coef(), pick_coef());
            for (int i = 0; i < BLOCK_ITEMS; i++)
            begin
                if ($urandom_range(49) == 0)
                    drain_results();
                send_index(random_index());
            end
        end

        drain_results();
        repeat (END_WAIT) @(negedge clk);

        $display("Checked %0d results from %0d requests over %0d coefficient settings,",
                 results_checked, requests_sent, settings_used);
        $display("with sender and receiver stalls in turn, then back-to-back; %0d errors.",
                 errors);
        if (errors == 0 && results_pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
